FILE: hdl/onewire_master_temp_reader_defines.svh
// ----------------------------------------------------------------------------
// One-wire master assertion macros
// Shared property forms for the one-wire master checks.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_MASTER_TEMP_READER_DEFINES_SVH
`define ONEWIRE_MASTER_TEMP_READER_DEFINES_SVH

// same-cycle implication
`define OMTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OMTR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/omtr_pkg.sv
// ----------------------------------------------------------------------------
// omtr_pkg
// Types and constants of the one-wire bus master.
// ----------------------------------------------------------------------------
package omtr_pkg;

  localparam int unsigned BitsPerByte = 8;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_W_LOW    = 3'd3,
    PH_W_DATA   = 3'd4,
    PH_R_LOW    = 3'd5,
    PH_R_WAIT   = 3'd6,
    PH_R_REC    = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    OP_RESET   = 3'd0,
    OP_WRITE   = 3'd1,
    OP_READ    = 3'd2,
    OP_CONVERT = 3'd3,
    OP_TEMP    = 3'd4
  } op_e;

  localparam logic [2:0] RegResetLow   = 3'd0;
  localparam logic [2:0] RegResetWait  = 3'd1;
  localparam logic [2:0] RegWriteLow   = 3'd2;
  localparam logic [2:0] RegWriteData  = 3'd3;
  localparam logic [2:0] RegReadLow    = 3'd4;
  localparam logic [2:0] RegReadSample = 3'd5;
  localparam logic [2:0] RegReadRecov  = 3'd6;

  localparam logic [7:0] CmdSkipRom = 8'hCC;
  localparam logic [7:0] CmdConvert = 8'h44;
  localparam logic [7:0] CmdReadPad = 8'hBE;

endpackage

FILE: hdl/onewire_master_temp_reader.sv
// ----------------------------------------------------------------------------
// onewire_master_temp_reader
// One-wire bus master with skip-ROM conversion and raw temperature read.
// ----------------------------------------------------------------------------
// Each input transaction is one microsecond tick and yields one result
// transaction. A tick is taken every clock cycle unless input is stalled: the
// slot sequencer state advances in a single registered step and the result is
// captured in an output register at the same edge, so a new tick is accepted
// in the same cycle the previous result leaves, and input stalls only while
// that result is held by the downstream side. The user must write timing
// registers through the cfg port while no command runs; the block does not check.
module onewire_master_temp_reader
  import omtr_pkg::*;
#(
  parameter int unsigned TICK_COUNTER_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        start_req_i,
  input  logic [2:0]  op_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        line_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        line_low_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic signed [15:0] temperature_o
);

  localparam int unsigned Tcb = TICK_COUNTER_BITS;
  localparam int unsigned Cw  = (Tcb > 10) ? Tcb : 10;
  localparam int unsigned BiW = $clog2(BitsPerByte);
  localparam logic [Tcb-1:0] CntLimit = '1;

  logic [9:0] rst_low_q, rst_wait_q;
  logic [7:0] w_low_q, w_data_q, r_low_q, r_sample_q, r_recov_q;

  phase_e           phase_q, phase_d, phase_cur;
  logic [Tcb-1:0]   tick_q, tick_d, tick_cur, cnt_inc;
  logic [BiW-1:0]   bit_q, bit_d, bit_cur;
  logic [7:0]       shift_q, shift_d, shift_cur;
  logic [2:0]       seq_q, seq_d, seq_cur;
  logic [7:0]       low_hold_q, low_hold_d;
  logic [15:0]      temp_q, temp_d;
  logic [2:0]       cmd_q, cmd_d;
  logic [7:0]       rx_q, rx_d;

  logic             in_acc, out_acc, start_ok, seg_end, unit_end, low, done;
  logic [9:0]       dur;
  logic [7:0]       byte_v;

  logic             out_valid_q, line_low_q, busy_q, done_q;
  logic [7:0]       rx_out_q;
  logic [15:0]      temp_out_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_low_q  <= 10'd550;
      rst_wait_q <= 10'd550;
      w_low_q    <= 8'd10;
      w_data_q   <= 8'd50;
      r_low_q    <= 8'd5;
      r_sample_q <= 8'd5;
      r_recov_q  <= 8'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegResetLow:   rst_low_q  <= cfg_data_i;
        RegResetWait:  rst_wait_q <= cfg_data_i;
        RegWriteLow:   w_low_q    <= cfg_data_i[7:0];
        RegWriteData:  w_data_q   <= cfg_data_i[7:0];
        RegReadLow:    r_low_q    <= cfg_data_i[7:0];
        RegReadSample: r_sample_q <= cfg_data_i[7:0];
        RegReadRecov:  r_recov_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign start_ok = (phase_q == PH_IDLE) && start_req_i && (op_i <= OP_TEMP);

  always_comb begin
    phase_cur = phase_q;
    tick_cur  = tick_q;
    bit_cur   = bit_q;
    shift_cur = shift_q;
    seq_cur   = seq_q;
    cmd_d     = cmd_q;
    if (start_ok) begin
      cmd_d    = op_i;
      seq_cur  = 3'd0;
      tick_cur = '0;
      bit_cur  = '0;
      case (op_i)
        OP_WRITE: begin
          shift_cur = tx_byte_i;
          phase_cur = PH_W_LOW;
        end
        OP_READ: begin
          shift_cur = 8'd0;
          phase_cur = PH_R_LOW;
        end
        default: phase_cur = PH_RST_LOW;
      endcase
    end
  end

  always_comb begin
    case (phase_cur)
      PH_RST_LOW:  dur = rst_low_q;
      PH_RST_WAIT: dur = rst_wait_q;
      PH_W_LOW:    dur = {2'b00, w_low_q};
      PH_W_DATA:   dur = {2'b00, w_data_q};
      PH_R_LOW:    dur = {2'b00, r_low_q};
      PH_R_WAIT:   dur = {2'b00, r_sample_q};
      PH_R_REC:    dur = {2'b00, r_recov_q};
      default:     dur = 10'd1;
    endcase
  end

  assign cnt_inc = tick_cur + {{(Tcb-1){1'b0}}, 1'b1};
  assign seg_end = (Cw'(cnt_inc) >= Cw'(dur)) || (cnt_inc == CntLimit);

  always_comb begin
    phase_d    = phase_cur;
    tick_d     = tick_cur;
    bit_d      = bit_cur;
    shift_d    = shift_cur;
    seq_d      = seq_cur;
    low_hold_d = low_hold_q;
    temp_d     = temp_q;
    rx_d       = rx_q;
    unit_end   = 1'b0;
    byte_v     = 8'd0;
    low        = 1'b0;
    done       = 1'b0;

    if (phase_cur != PH_IDLE) begin
      tick_d = seg_end ? '0 : cnt_inc;
    end

    case (phase_cur)
      PH_RST_LOW: begin
        low = 1'b1;
        if (seg_end) phase_d = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        if (seg_end) unit_end = 1'b1;
      end
      PH_W_LOW: begin
        low = 1'b1;
        if (seg_end) phase_d = PH_W_DATA;
      end
      PH_W_DATA: begin
        low = ~shift_cur[0];
        if (seg_end) begin
          shift_d = {1'b0, shift_cur[7:1]};
          bit_d   = bit_cur + 1'b1;
          if (bit_d == '0) begin
            unit_end = 1'b1;
            byte_v   = shift_d;
          end else begin
            phase_d = PH_W_LOW;
          end
        end
      end
      PH_R_LOW: begin
        low = 1'b1;
        if (seg_end) phase_d = PH_R_WAIT;
      end
      PH_R_WAIT: begin
        if (seg_end) phase_d = PH_R_REC;
      end
      PH_R_REC: begin
        if (tick_cur == '0) shift_d = {line_in_i, shift_cur[7:1]};
        if (seg_end) begin
          bit_d = bit_cur + 1'b1;
          if (bit_d == '0) begin
            unit_end = 1'b1;
            byte_v   = shift_d;
          end else begin
            phase_d = PH_R_LOW;
          end
        end
      end
      default: ;
    endcase

    if (unit_end) begin
      seq_d = seq_cur + 3'd1;
      case (cmd_d)
        OP_READ: begin
          rx_d    = byte_v;
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
        OP_CONVERT: begin
          if (seq_cur <= 3'd1) begin
            shift_d = (seq_cur == 3'd0) ? CmdSkipRom : CmdConvert;
            bit_d   = '0;
            phase_d = PH_W_LOW;
          end else begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
        OP_TEMP: begin
          if (seq_cur <= 3'd1) begin
            shift_d = (seq_cur == 3'd0) ? CmdSkipRom : CmdReadPad;
            bit_d   = '0;
            phase_d = PH_W_LOW;
          end else if (seq_cur <= 3'd3) begin
            if (seq_cur == 3'd3) low_hold_d = byte_v;
            shift_d = 8'd0;
            bit_d   = '0;
            phase_d = PH_R_LOW;
          end else begin
            temp_d  = {byte_v, low_hold_q};
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          done    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tick_q     <= '0;
      bit_q      <= '0;
      shift_q    <= 8'd0;
      seq_q      <= 3'd0;
      low_hold_q <= 8'd0;
      temp_q     <= 16'd0;
      cmd_q      <= 3'd0;
      rx_q       <= 8'd0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      tick_q     <= tick_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      seq_q      <= seq_d;
      low_hold_q <= low_hold_d;
      temp_q     <= temp_d;
      cmd_q      <= cmd_d;
      rx_q       <= rx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_low_q <= low;
      busy_q     <= (phase_cur != PH_IDLE);
      done_q     <= done;
      rx_out_q   <= rx_d;
      temp_out_q <= temp_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_low_o    = line_low_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;
  assign rx_byte_o     = rx_out_q;
  assign temperature_o = $signed(temp_out_q);

`include "onewire_master_temp_reader_defines.svh"

  `OMTR_ASSERT_NOW(a_done_busy, out_valid_q && done_q, busy_q, "done without busy")
  `OMTR_ASSERT_NOW(a_idle_release, out_valid_q && !busy_q, !line_low_q, "line low when idle")
  `OMTR_ASSERT_NOW(a_tick_limit, 1'b1, tick_q != CntLimit, "tick counter saturated")
  `OMTR_ASSERT_NEXT(a_stay_idle, in_acc && (phase_q == PH_IDLE) && !start_req_i, phase_q == PH_IDLE, "left idle without request")

endmodule
